// ----- design/complementary_attitude_filter_assert.svh -----
// ----------------------------------------------------------------------------
// Complementary attitude filter assertion macros
// Concurrent assertion shorthands clocked on aclk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COMPLEMENTARY_ATTITUDE_FILTER_ASSERT_SVH
`define COMPLEMENTARY_ATTITUDE_FILTER_ASSERT_SVH

// Same-cycle implication.
`define CAF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CAF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Invariant.
`define CAF_ASSERT_ALWAYS(label, cond, msg) \
    `CAF_ASSERT_IMPL(label, 1'b1, cond, msg)

`endif

// ----- design/caf_pkg.sv -----
// ----------------------------------------------------------------------------
// Complementary attitude filter package
// Angle constants, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package caf_pkg;

    localparam logic signed [32:0] DEG180 = 33'sd11796480;
    localparam logic signed [32:0] DEG360 = 33'sd23592960;
    localparam logic signed [25:0] DEG90  = 26'sd5898240;
    localparam logic [17:0] GATE_LOW  = 18'd1843;
    localparam logic [17:0] GATE_HIGH = 18'd8602;
    localparam logic [15:0] DISARMED_WEIGHT = 16'd3277;
    localparam int CORDIC_STEPS = 20;

    // Configuration register indexes
    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_WEIGHT = 2'd1;

    // atan(2^-i) in Q16.16 degrees
    function automatic logic [21:0] atan_lut(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/complementary_attitude_filter.sv -----
// ----------------------------------------------------------------------------
// Complementary attitude filter
// Gyro integration with accelerometer blend of pitch and roll.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per sensor sample. s_tdata holds the three gyro
//   rates and three accelerations, s_tuser the armed flag.
//   m_ channel: one result item per input item with pitch, roll and yaw;
//   m_tuser says whether the accelerometer blend was applied.
//   cfg_ port: index 0 writes the sample period, index 1 the armed weight;
//   write only while the block is idle.
// Flow:
//   The block waits for the two CORDIC passes (20 steps each, one shared
//   unit) only when the magnitude gate passes, and a pass runs no steps when
//   its tilt vector is all zero; one multiplier serves integration and
//   blending in turn. One item is in flight at a time: s_tready is high only
//   in the idle state, so no new item is taken until the last result has
//   been loaded into the output register.
// Reset: estimates clear to zero, registers take their defaults.
// Stall: a finished result waits in the output register; the next item may
//   be accepted and worked on, and its result waits until m_tready frees it.
// ----------------------------------------------------------------------------
module complementary_attitude_filter (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [28:0] gyro_pitch_rate, [57:29] gyro_roll_rate, [86:58] gyro_yaw_rate,
    // [102:87] accel_x, [118:103] accel_y, [134:119] accel_z, [135] zero
    input  logic [135:0] s_tdata,
    // [0] armed
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] pitch_angle, [63:32] roll_angle, [88:64] yaw_angle, [95:89] zero
    output logic [95:0]  m_tdata,
    // [0] accel_used
    output logic         m_tuser,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_wdata
);

    `include "complementary_attitude_filter_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_MP, S_MR, S_MY, S_YW, S_CW1, S_B1, S_B2, S_B3,
        S_CW2, S_B4, S_B5, S_B6, S_OUT
    } state_t;

    state_t state_reg;

    logic [23:0] period_reg;
    logic [15:0] weight_reg;

    logic signed [31:0] pitch_reg, roll_reg, yaw_reg;
    logic signed [28:0] rp_reg, rr_reg, ry_reg;
    logic signed [15:0] ay_reg, az_reg;
    logic               armed_reg, used_reg;
    logic signed [25:0] atan_reg;
    logic signed [58:0] prod_reg, p1_reg;

    logic         m_tvalid_reg, m_tuser_reg;
    logic [95:0]  m_tdata_reg;

    logic               accept;
    logic               cordic_start, cordic_done;
    logic signed [15:0] cordic_num, cordic_den;
    logic signed [25:0] cordic_angle;

    logic signed [15:0] in_ax, in_ay, in_az;
    logic [16:0]        abs_x, abs_y, abs_z;
    logic [17:0]        mag;

    logic [15:0]        weight;
    logic [16:0]        gyro_weight;
    logic signed [32:0] mul_a;
    logic signed [25:0] mul_b;

    logic signed [59:0] rnd;
    logic signed [27:0] delta;
    logic signed [31:0] int_base, int_sat;
    logic signed [33:0] int_sum;
    logic signed [32:0] yaw_wrap;

    logic signed [59:0] bsum;
    logic signed [43:0] bsh;
    logic signed [31:0] blend_sat;

    logic               yaw_in_range;
    logic               cordic_nonzero;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    assign in_ax = $signed(s_tdata[102:87]);
    assign in_ay = $signed(s_tdata[118:103]);
    assign in_az = $signed(s_tdata[134:119]);

    // Magnitude gate on |ax|+|ay|+|az|
    assign abs_x = in_ax[15] ? (17'd0 - {1'b1, in_ax}) : {1'b0, in_ax};
    assign abs_y = in_ay[15] ? (17'd0 - {1'b1, in_ay}) : {1'b0, in_ay};
    assign abs_z = in_az[15] ? (17'd0 - {1'b1, in_az}) : {1'b0, in_az};
    assign mag   = {1'b0, abs_x} + {1'b0, abs_y} + {1'b0, abs_z};

    // Pitch CORDIC starts on accept; roll CORDIC after the pitch blend
    assign cordic_start = accept || (state_reg == S_B3);
    assign cordic_num   = (state_reg == S_IDLE) ? in_ax : ay_reg;
    assign cordic_den   = (state_reg == S_IDLE) ? in_az : az_reg;

    caf_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .num     (cordic_num),
        .den     (cordic_den),
        .done    (cordic_done),
        .angle   (cordic_angle)
    );

    assign weight      = armed_reg ? weight_reg : caf_pkg::DISARMED_WEIGHT;
    assign gyro_weight = 17'h10000 - {1'b0, weight};

    // Shared multiplier operand selection
    always_comb begin
        case (state_reg)
            S_MP: begin
                mul_a = 33'(rp_reg);
                mul_b = $signed({2'b0, period_reg});
            end
            S_MR: begin
                mul_a = 33'(rr_reg);
                mul_b = $signed({2'b0, period_reg});
            end
            S_MY: begin
                mul_a = 33'(ry_reg);
                mul_b = $signed({2'b0, period_reg});
            end
            S_B1: begin
                mul_a = 33'(pitch_reg);
                mul_b = $signed({9'b0, gyro_weight});
            end
            S_B4: begin
                mul_a = 33'(roll_reg);
                mul_b = $signed({9'b0, gyro_weight});
            end
            S_B2, S_B5: begin
                mul_a = 33'(atan_reg);
                mul_b = $signed({10'b0, weight});
            end
            default: begin
                mul_a = 33'sd0;
                mul_b = 26'sd0;
            end
        endcase
    end

    // Integration: round product to Q16.16, add, saturate
    assign rnd   = 60'(prod_reg) + 60'sd2147483648;
    assign delta = rnd[59:32];

    always_comb begin
        case (state_reg)
            S_MR:    int_base = pitch_reg;
            S_MY:    int_base = roll_reg;
            default: int_base = yaw_reg;
        endcase
    end

    assign int_sum = 34'(int_base) + 34'(delta);
    assign int_sat = (int_sum[33:31] == 3'b000 || int_sum[33:31] == 3'b111) ? int_sum[31:0]
                   : (int_sum[33] ? 32'sh80000000 : 32'sh7fffffff);

    // Yaw wraps once by a full turn
    always_comb begin
        if (33'(int_sat) > caf_pkg::DEG180) begin
            yaw_wrap = 33'(int_sat) - caf_pkg::DEG360;
        end else if (33'(int_sat) < -caf_pkg::DEG180) begin
            yaw_wrap = 33'(int_sat) + caf_pkg::DEG360;
        end else begin
            yaw_wrap = 33'(int_sat);
        end
    end

    // Blend: round, shift down, saturate
    assign bsum = 60'(p1_reg) + 60'(prod_reg) + 60'sd32768;
    assign bsh  = bsum[59:16];
    assign blend_sat = (bsh[43:31] == 13'h0000 || bsh[43:31] == 13'h1fff) ? bsh[31:0]
                     : (bsh[43] ? 32'sh80000000 : 32'sh7fffffff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            period_reg   <= 24'd4294967;
            weight_reg   <= 16'd3277;
            pitch_reg    <= 32'sd0;
            roll_reg     <= 32'sd0;
            yaw_reg      <= 32'sd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    caf_pkg::REG_PERIOD: period_reg <= cfg_wdata;
                    caf_pkg::REG_WEIGHT: weight_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end

            // Drop the result once taken, unless a new one is loaded below
            if (m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            prod_reg <= mul_a * mul_b;

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        rp_reg    <= $signed(s_tdata[28:0]);
                        rr_reg    <= $signed(s_tdata[57:29]);
                        ry_reg    <= $signed(s_tdata[86:58]);
                        ay_reg    <= in_ay;
                        az_reg    <= in_az;
                        armed_reg <= s_tuser;
                        used_reg  <= (mag > caf_pkg::GATE_LOW) && (mag < caf_pkg::GATE_HIGH);
                        state_reg <= S_MP;
                    end
                end
                S_MP: state_reg <= S_MR;
                S_MR: begin
                    pitch_reg <= int_sat;
                    state_reg <= S_MY;
                end
                S_MY: begin
                    roll_reg  <= int_sat;
                    state_reg <= S_YW;
                end
                S_YW: begin
                    yaw_reg   <= yaw_wrap[31:0];
                    state_reg <= used_reg ? S_CW1 : S_OUT;
                end
                S_CW1: begin
                    if (cordic_done) begin
                        atan_reg  <= cordic_angle;
                        state_reg <= S_B1;
                    end
                end
                S_B1: state_reg <= S_B2;
                S_B2: begin
                    p1_reg    <= prod_reg;
                    state_reg <= S_B3;
                end
                S_B3: begin
                    pitch_reg <= blend_sat;
                    state_reg <= S_CW2;
                end
                S_CW2: begin
                    if (cordic_done) begin
                        atan_reg  <= cordic_angle;
                        state_reg <= S_B4;
                    end
                end
                S_B4: state_reg <= S_B5;
                S_B5: begin
                    p1_reg    <= prod_reg;
                    state_reg <= S_B6;
                end
                S_B6: begin
                    roll_reg  <= blend_sat;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {7'b0, yaw_reg[24:0], roll_reg, pitch_reg};
                        m_tuser_reg  <= used_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign yaw_in_range   = (33'(yaw_reg) <= caf_pkg::DEG180) &&
                            (33'(yaw_reg) >= -caf_pkg::DEG180);
    assign cordic_nonzero = (cordic_num != 16'sd0) || (cordic_den != 16'sd0);

    `CAF_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "input accepted while busy")
    `CAF_ASSERT_NEXT(a_cordic_restart, cordic_start && cordic_nonzero, !cordic_done, "stale CORDIC result")
    `CAF_ASSERT_ALWAYS(a_yaw_range, yaw_in_range, "yaw out of range")

endmodule

// ----- design/caf_cordic.sv -----
// ----------------------------------------------------------------------------
// CORDIC atan2
// Iterative vectoring CORDIC, one step a cycle, result in Q16.16 degrees.
// ----------------------------------------------------------------------------
module caf_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] num,
    input  logic signed [15:0] den,
    output logic               done,
    output logic signed [25:0] angle
);

    logic signed [33:0] x_reg, y_reg;
    logic signed [25:0] acc_reg;
    logic [4:0]         step_reg;
    logic               run_reg;
    logic               done_reg;

    logic signed [33:0] xs, ys, x0, y0;
    logic signed [25:0] lut;

    assign xs  = x_reg >>> step_reg;
    assign ys  = y_reg >>> step_reg;
    assign lut = $signed({4'b0, caf_pkg::atan_lut(step_reg)});
    assign x0  = 34'($signed(den)) <<< 14;
    assign y0  = 34'($signed(num)) <<< 14;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            step_reg <= 5'd0;
            done_reg <= 1'b0;
            if (num == 16'sd0 && den == 16'sd0) begin
                acc_reg  <= 26'sd0;
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                run_reg <= 1'b1;
                if (x0 < 0) begin
                    if (y0 >= 0) begin
                        x_reg   <= y0;
                        y_reg   <= -x0;
                        acc_reg <= caf_pkg::DEG90;
                    end else begin
                        x_reg   <= -y0;
                        y_reg   <= x0;
                        acc_reg <= -caf_pkg::DEG90;
                    end
                end else begin
                    x_reg   <= x0;
                    y_reg   <= y0;
                    acc_reg <= 26'sd0;
                end
            end
        end else if (run_reg) begin
            if (y_reg >= 0) begin
                x_reg   <= x_reg + ys;
                y_reg   <= y_reg - xs;
                acc_reg <= acc_reg + lut;
            end else begin
                x_reg   <= x_reg - ys;
                y_reg   <= y_reg + xs;
                acc_reg <= acc_reg - lut;
            end
            step_reg <= step_reg + 5'd1;
            if (step_reg == 5'(caf_pkg::CORDIC_STEPS - 1)) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done  = done_reg;
    assign angle = acc_reg;

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// Complementary attitude filter testbench
// Drives gyro and accelerometer items with random bursts and gaps, stalls the
// result side, predicts pitch, roll, yaw and the blend flag per item, and
// compares every result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
        logic signed [24:0] yaw;
        logic               used;
    } attitude_t;

    // Attitude predictor and store of expected attitudes
    class attitude_board;
        longint   period;
        longint   armed_weight;
        longint   pitch_est, roll_est, yaw_est;
        attitude_t pending[$];
        int       errors;

        function new();
            period = 4294967; armed_weight = 3277;
            pitch_est = 0; roll_est = 0; yaw_est = 0; errors = 0;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // floor shift; >>> on longint is arithmetic, which floors
        function longint fshift(longint v, int s);
            return v >>> s;
        endfunction

        function longint tilt_deg(longint num, longint den);
            longint x, y, t, acc, xs, ys;
            acc = 0;
            if (num == 0 && den == 0) return 0;
            x = den * 16384; y = num * 16384;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; acc = caf_pkg::DEG90;
                end else begin
                    t = x; x = -y; y = t; acc = -caf_pkg::DEG90;
                end
            end
            for (int i = 0; i < caf_pkg::CORDIC_STEPS; i++) begin
                xs = fshift(x, i); ys = fshift(y, i);
                if (y >= 0) begin
                    x = x + ys; y = y - xs; acc += longint'(caf_pkg::atan_lut(5'(i)));
                end else begin
                    x = x - ys; y = y + xs; acc -= longint'(caf_pkg::atan_lut(5'(i)));
                end
            end
            return acc;
        endfunction

        function longint step_angle(longint a, longint rate);
            return sat32(a + fshift(rate * period + (64'sd1 <<< 31), 32));
        endfunction

        function longint mix(longint a, longint acc, longint w);
            return sat32(fshift(a * (65536 - w) + acc * w + 32768, 16));
        endfunction

        function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        function void note_sample(logic [135:0] d, logic armed);
            longint rp, rr, ry, ax, ay, az, w, m;
            attitude_t e;
            rp = longint'($signed(d[28:0]));
            rr = longint'($signed(d[57:29]));
            ry = longint'($signed(d[86:58]));
            ax = longint'($signed(d[102:87]));
            ay = longint'($signed(d[118:103]));
            az = longint'($signed(d[134:119]));
            pitch_est = step_angle(pitch_est, rp);
            roll_est = step_angle(roll_est, rr);
            yaw_est = step_angle(yaw_est, ry);
            if (yaw_est > caf_pkg::DEG180) yaw_est -= caf_pkg::DEG360;
            else if (yaw_est < -caf_pkg::DEG180) yaw_est += caf_pkg::DEG360;
            m = mag(ax) + mag(ay) + mag(az);
            e.used = (m > caf_pkg::GATE_LOW) && (m < caf_pkg::GATE_HIGH);
            if (e.used) begin
                w = armed ? armed_weight : longint'(caf_pkg::DISARMED_WEIGHT);
                pitch_est = mix(pitch_est, tilt_deg(ax, az), w);
                roll_est = mix(roll_est, tilt_deg(ay, az), w);
            end
            e.pitch = pitch_est[31:0]; e.roll = roll_est[31:0]; e.yaw = yaw_est[24:0];
            pending.push_back(e);
        endfunction

        function void check_attitude(logic [95:0] d, logic used);
            attitude_t e;
            if (pending.size() == 0) begin
                $error("result with no expected attitude waiting");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.pitch) begin
                $error("pitch_angle exp %0d got %0d", e.pitch, $signed(d[31:0])); errors++;
            end
            if (d[63:32] !== e.roll) begin
                $error("roll_angle exp %0d got %0d", e.roll, $signed(d[63:32])); errors++;
            end
            if (d[88:64] !== e.yaw) begin
                $error("yaw_angle exp %0d got %0d", e.yaw, $signed(d[88:64])); errors++;
            end
            if (used !== e.used) begin
                $error("accel_used exp %0b got %0b", e.used, used); errors++;
            end
        endfunction
    endclass

    localparam logic [1:0] REG_SPARE  = 2'd3;

    logic aclk = 1'b0, aresetn = 1'b0;
    logic s_tvalid = 1'b0, s_tready, s_tuser = 1'b0;
    logic [135:0] s_tdata = '0;
    logic m_tvalid, m_tready = 1'b0, m_tuser;
    logic [95:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [23:0] cfg_wdata = '0;

    attitude_board board = new();
    bit long_hold = 1'b0;
    bit stim_done = 1'b0;

    complementary_attitude_filter dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Score every accepted item on both sides at the clock edge
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.note_sample(s_tdata, s_tuser);
        if (aresetn && m_tvalid && m_tready) board.check_attitude(m_tdata, m_tuser);
    end

    // Receiver stalls on a pattern of its own; long hold-off when asked
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(posedge aclk);
            phase++;
            if (long_hold) m_tready <= 1'b0;
            else if ((phase / 200) % 3 == 0) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Pulse one write, then drop the enable and wait before the next
    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == caf_pkg::REG_PERIOD) board.period = val;
        else if (idx == caf_pkg::REG_WEIGHT) board.armed_weight = val[15:0];
        @(posedge aclk);
    endtask

    // Stop offering, hold until the store drains, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // Offer one item and hold it until accepted; valid stays up for the next
    task automatic send_sample(logic signed [28:0] rp, rr, ry,
                               logic signed [15:0] ax, ay, az, logic armed);
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, az, ay, ax, ry, rr, rp};
        s_tuser <= armed;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic signed [28:0] any_rate();
        case ($urandom_range(0, 5))
            0: return 29'sd262144000;
            1: return -29'sd262144000;
            2: return 29'($urandom);
            default: return 29'($signed($urandom_range(0, 2 * 65536 * 400)) - 65536 * 400);
        endcase
    endfunction

    // Mostly inside the magnitude gate so the blend is exercised
    function automatic logic signed [15:0] any_accel(bit gated);
        if (gated) return 16'($signed($urandom_range(0, 5000)) - 2500);
        return 16'($urandom);
    endfunction

    task automatic random_run(int n);
        bit g;
        int gap;
        for (int i = 0; i < n; i++) begin
            g = ($urandom_range(0, 4) != 0);
            send_sample(any_rate(), any_rate(), any_rate(),
                        any_accel(g), any_accel(g), any_accel(g), 1'($urandom));
            if (i % ($urandom_range(1, 12)) == 0) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero period, gate edges, quadrants, both-zero tilt
        write_reg(caf_pkg::REG_PERIOD, 24'd0);
        write_reg(caf_pkg::REG_WEIGHT, 16'hFFFF);
        send_sample(29'sd262144000, -29'sd262144000, 29'sd1, 16'sd4096, 0, 0, 1'b1);
        send_sample(0, 0, 0, 16'sd1843, 0, 0, 1'b1);
        send_sample(0, 0, 0, 16'sd1844, 0, 0, 1'b1);
        send_sample(0, 0, 0, 0, 0, 16'sd8601, 1'b0);
        send_sample(0, 0, 0, 0, 0, 16'sd8602, 1'b1);
        send_sample(0, 0, 0, 16'sd2000, 16'sd2000, -16'sd3000, 1'b1);
        send_sample(0, 0, 0, -16'sd2000, -16'sd2000, -16'sd3000, 1'b1);
        send_sample(0, 0, 0, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0);
        drain();
        write_reg(REG_SPARE, 24'hFFFFFF);
        write_reg(caf_pkg::REG_PERIOD, 24'hFFFFFF);
        write_reg(caf_pkg::REG_WEIGHT, 16'd0);
        for (int i = 0; i < 12; i++)
            send_sample(29'sd262144000, -29'sd262144000, 29'sd262144000,
                        0, 0, 16'sd4096, 1'(i));
        for (int i = 0; i < 4; i++)
            send_sample(-29'sd262144000, 29'sd262144000, -29'sd262144000,
                        0, 0, 16'sd4096, 1'b1);
        drain();

        // Long hold-off on the result side while items keep coming
        fork
            begin
                long_hold = 1'b1;
                repeat (400) @(posedge aclk);
                long_hold = 1'b0;
            end
            random_run(6);
        join
        drain();

        write_reg(caf_pkg::REG_PERIOD, 24'd1);
        write_reg(caf_pkg::REG_WEIGHT, 16'd3277);
        random_run(400);
        drain();
        write_reg(caf_pkg::REG_PERIOD, 24'd4294967 & 24'hFFFFFF);
        write_reg(caf_pkg::REG_WEIGHT, 16'd40000);
        random_run(550);
        drain();
        write_reg(caf_pkg::REG_PERIOD, 24'($urandom_range(1, 24'hFFFFFF)));
        write_reg(caf_pkg::REG_WEIGHT, 16'($urandom));
        random_run(530);
        drain();
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (board.errors == 0 && board.pending.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end
endmodule
